[design/rlmp_pkg.sv]
// Shared types and constants for the register list mask parser.
`timescale 1ns / 1ps
`default_nettype none

package rlmp_pkg;

    localparam int MAX_TEXT_LENGTH_DEFAULT = 256;

    // ASCII codes the parser looks for
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_D  = 8'h44;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_SYNTAX   = 2'd2,
        ST_NOT_LIST = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] text_char;
        logic       first_char;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [15:0] register_mask;
        logic [7:0]  list_length;
    } t_out_word;

    // Classification of one case-folded character
    typedef struct packed {
        logic       is_letter;  // A or D
        logic       is_addr;    // A
        logic       is_digit;   // 0..7
        logic [2:0] digit;
        logic       is_term;    // , / - NUL or white space
        logic       is_slash;
        logic       is_dash;
    } t_char_class;

endpackage

`default_nettype wire

[design/rlmp_char_class.sv]
// Case folding and classification of one operand character.
`timescale 1ns / 1ps
`default_nettype none

module rlmp_char_class
    import rlmp_pkg::*;
(
    input  wire logic [7:0]  i_char,
    output t_char_class      o_class
);

    logic [7:0] up_char;

    always_comb begin
        up_char = i_char;
        if (i_char >= CHAR_LO_A && i_char <= CHAR_LO_Z) begin
            up_char = i_char - CASE_DELTA;
        end

        o_class.is_addr   = (up_char == CHAR_UP_A);
        o_class.is_letter = (up_char == CHAR_UP_A) || (up_char == CHAR_UP_D);
        o_class.is_digit  = (up_char >= CHAR_ZERO) && (up_char <= CHAR_SEVEN);
        o_class.digit     = up_char[2:0];
        o_class.is_slash  = (up_char == CHAR_SLASH);
        o_class.is_dash   = (up_char == CHAR_DASH);
        o_class.is_term   = (up_char == CHAR_COMMA) || (up_char == CHAR_SLASH) ||
                            (up_char == CHAR_DASH) || (up_char == CHAR_NUL) ||
                            (up_char == CHAR_SPACE) ||
                            ((up_char >= CHAR_TAB) && (up_char <= CHAR_CR));
    end

endmodule

`default_nettype wire

[design/register_list_mask_parser.sv]
// A word accepted at one edge shows its result at the output in the next cycle.
// One character word per cycle unless the output stalls; the parse state updates
// in a single pass of logic between the state registers and the result register.
// Reset (i_rst_n low, synchronous): parser waits for a first character, mask and
// character count clear, the result register empties.
`timescale 1ns / 1ps
`default_nettype none

module register_list_mask_parser
    import rlmp_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = MAX_TEXT_LENGTH_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);

    localparam int CW = $clog2(MAX_TEXT_LENGTH + 1);
    localparam logic [CW-1:0] LastIdx = CW'(MAX_TEXT_LENGTH - 1);
    localparam logic [CW-1:0] MaxCnt  = CW'(MAX_TEXT_LENGTH);

    typedef enum logic [3:0] {
        PH_START,
        PH_FIRST_DIGIT,
        PH_FIRST_SEP,
        PH_ITEM_LETTER,
        PH_ITEM_DIGIT,
        PH_ITEM_SEP,
        PH_RANGE_LETTER,
        PH_RANGE_DIGIT,
        PH_RANGE_TERM,
        PH_DONE_OK,
        PH_DONE_SYNTAX,
        PH_DONE_NOTLIST
    } t_phase;

    t_phase          r_phase, n_phase, cur_phase;
    logic [15:0]     r_mask, n_mask, cur_mask;
    logic [3:0]      r_pend, n_pend, cur_pend;
    logic [3:0]      r_rstart, n_rstart, cur_rstart;
    logic [CW-1:0]   r_cnt, n_cnt, cur_cnt;
    logic            r_out_valid;
    t_out_word       r_out, n_out;

    logic            accept;
    logic [7:0]      eff_char;
    t_char_class     cls;
    logic            set_en;
    logic [3:0]      set_a, set_b, lo, hi;
    logic [15:0]     range_bits;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // first_char restarts the parse from the reset state
    always_comb begin
        cur_phase  = i_in_data.first_char ? PH_START : r_phase;
        cur_mask   = i_in_data.first_char ? 16'h0000 : r_mask;
        cur_pend   = i_in_data.first_char ? 4'h0 : r_pend;
        cur_rstart = i_in_data.first_char ? 4'h0 : r_rstart;
        cur_cnt    = i_in_data.first_char ? '0 : r_cnt;
        // at the last buffer position and beyond, read NUL
        eff_char   = (cur_cnt >= LastIdx) ? CHAR_NUL : i_in_data.text_char;
    end

    rlmp_char_class u_char_class (
        .i_char  (eff_char),
        .o_class (cls)
    );

    always_comb begin
        n_phase  = cur_phase;
        n_pend   = cur_pend;
        n_rstart = cur_rstart;
        n_cnt    = cur_cnt;
        set_en   = 1'b0;
        set_a    = cur_pend;
        set_b    = cur_pend;

        if (!(cur_phase inside {PH_DONE_OK, PH_DONE_SYNTAX, PH_DONE_NOTLIST})) begin
            if (cur_cnt < MaxCnt) begin
                n_cnt = cur_cnt + 1'b1;
            end
            case (cur_phase)
                PH_START: begin
                    if (cls.is_letter) begin
                        n_pend  = {cls.is_addr, 3'b000};
                        n_phase = PH_FIRST_DIGIT;
                    end else begin
                        n_phase = PH_DONE_NOTLIST;
                    end
                end
                PH_FIRST_DIGIT: begin
                    if (cls.is_digit) begin
                        n_pend  = cur_pend | {1'b0, cls.digit};
                        n_phase = PH_FIRST_SEP;
                    end else begin
                        n_phase = PH_DONE_NOTLIST;
                    end
                end
                PH_ITEM_LETTER, PH_RANGE_LETTER: begin
                    if (cls.is_letter) begin
                        if (cur_phase == PH_RANGE_LETTER) begin
                            n_rstart = cur_pend;
                        end
                        n_pend  = {cls.is_addr, 3'b000};
                        n_phase = (cur_phase == PH_ITEM_LETTER) ? PH_ITEM_DIGIT
                                                                : PH_RANGE_DIGIT;
                    end else begin
                        n_phase = PH_DONE_SYNTAX;
                    end
                end
                PH_ITEM_DIGIT, PH_RANGE_DIGIT: begin
                    if (cls.is_digit) begin
                        n_pend  = cur_pend | {1'b0, cls.digit};
                        n_phase = (cur_phase == PH_ITEM_DIGIT) ? PH_ITEM_SEP
                                                               : PH_RANGE_TERM;
                    end else begin
                        n_phase = PH_DONE_SYNTAX;
                    end
                end
                PH_FIRST_SEP, PH_ITEM_SEP: begin
                    if (cur_phase == PH_FIRST_SEP && !cls.is_term) begin
                        n_phase = PH_DONE_NOTLIST;
                    end else if (cls.is_slash) begin
                        set_en  = 1'b1;
                        n_phase = PH_ITEM_LETTER;
                    end else if (cls.is_dash) begin
                        n_phase = PH_RANGE_LETTER;
                    end else begin
                        // list ends; terminator not counted
                        set_en  = 1'b1;
                        n_cnt   = cur_cnt;
                        n_phase = PH_DONE_OK;
                    end
                end
                PH_RANGE_TERM: begin
                    if (!cls.is_term || cls.is_dash) begin
                        n_phase = PH_DONE_SYNTAX;
                    end else begin
                        set_en = 1'b1;
                        set_a  = cur_rstart;
                        if (cls.is_slash) begin
                            n_phase = PH_ITEM_LETTER;
                        end else begin
                            n_cnt   = cur_cnt;
                            n_phase = PH_DONE_OK;
                        end
                    end
                end
                default: begin
                    n_phase = PH_DONE_SYNTAX;
                end
            endcase
        end
    end

    // bits lo..hi of the range, either end order
    always_comb begin
        lo = (set_a < set_b) ? set_a : set_b;
        hi = (set_a < set_b) ? set_b : set_a;
        for (int i = 0; i < 16; i++) begin
            range_bits[i] = (4'(i) >= lo) && (4'(i) <= hi);
        end
        n_mask = set_en ? (cur_mask | range_bits) : cur_mask;
    end

    always_comb begin
        n_out = '0;
        case (n_phase)
            PH_DONE_OK: begin
                n_out.parse_status  = ST_DONE;
                n_out.register_mask = n_mask;
                n_out.list_length   = (int'(n_cnt) > 255) ? 8'hFF : 8'(n_cnt);
            end
            PH_DONE_SYNTAX: begin
                n_out.parse_status = ST_SYNTAX;
            end
            PH_DONE_NOTLIST: begin
                n_out.parse_status = ST_NOT_LIST;
            end
            default: begin
                n_out.parse_status  = ST_BUSY;
                n_out.register_mask = n_mask;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_mask      <= '0;
            r_pend      <= '0;
            r_rstart    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_mask      <= n_mask;
                r_pend      <= n_pend;
                r_rstart    <= n_rstart;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                // drop the word once taken
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result of the last accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[tb/register_list_mask_parser_tb.sv]
// Self-checking testbench for the register list mask parser.
`timescale 1ns / 1ps

module register_list_mask_parser_tb;
    import rlmp_pkg::*;

    localparam int TEXT_MAX  = MAX_TEXT_LENGTH_DEFAULT;
    localparam int DIR_COUNT = 25;
    localparam int ITEM_GOAL = DIR_COUNT + 600;

    typedef enum logic [3:0] {
        P_IDLE, P_LEAD_DIGIT, P_LEAD_SEP, P_NEXT_LETTER, P_NEXT_DIGIT, P_NEXT_SEP,
        P_HI_LETTER, P_HI_DIGIT, P_HI_END, P_ENDED, P_BAD, P_NAMED
    } t_phase;

    typedef struct packed {
        logic [7:0]  ch;
        logic        first;
        logic        typed;
        logic [1:0]  st;
        logic [15:0] mask;
        logic [7:0]  len;
    } t_row;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_char_item;

    // Fixed cases; the result is typed in only where it is obvious.
    localparam t_row DIR_ROWS [DIR_COUNT] = '{
        // no first flag after reset: "d0-d3/a5" then NUL, then a repeat
        '{"d", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"0", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"-", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"d", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"3", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"/", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"a", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"5", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{CHAR_NUL, 1'b0, 1'b1, ST_DONE, 16'h200F, 8'd8},
        '{8'hFF,    1'b0, 1'b1, ST_DONE, 16'h200F, 8'd8},
        // reversed full range A7-D0 ended by tab
        '{"A", 1'b1, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"7", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"-", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"D", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"0", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{CHAR_TAB, 1'b0, 1'b1, ST_DONE, 16'hFFFF, 8'd5},
        // high byte as first character
        '{8'h80, 1'b1, 1'b1, ST_NOT_LIST, 16'h0, 8'd0},
        // D8 is no register
        '{"D", 1'b1, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"8", 1'b0, 1'b1, ST_NOT_LIST, 16'h0, 8'd0},
        // range end followed by a dash
        '{"a", 1'b1, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"1", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"-", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"a", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"2", 1'b0, 1'b0, ST_BUSY, 16'h0, 8'd0},
        '{"-", 1'b0, 1'b1, ST_SYNTAX, 16'h0, 8'd0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_data;

    register_list_mask_parser #(
        .MAX_TEXT_LENGTH(TEXT_MAX)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Parser model state
    t_phase      phase = P_IDLE;
    logic [15:0] mask_acc = '0;
    logic [3:0]  cur_reg = '0;
    logic [3:0]  range_lo = '0;
    logic [15:0] seen = '0;

    t_char_item  char_q[$];
    t_out_word   result_q[$];
    logic [7:0]  op_chars[$];
    int          faults = 0;

    task automatic log_fault(input string msg);
        $display("[%0t] %s", $time, msg);
        faults++;
    endtask

    function automatic logic [15:0] span_bits(input logic [3:0] a, input logic [3:0] b);
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [15:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (i >= lo && i <= hi) m[i] = 1'b1;
        end
        return m;
    endfunction

    function automatic bit is_reg_letter(input logic [7:0] c);
        return c == CHAR_UP_A || c == CHAR_UP_D;
    endfunction

    function automatic bit is_reg_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_SEVEN;
    endfunction

    function automatic bit is_list_end(input logic [7:0] c);
        return c == CHAR_COMMA || c == CHAR_SLASH || c == CHAR_DASH || c == CHAR_NUL ||
               c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    task automatic close_list(input logic [15:0] pos);
        seen = pos;
        phase = P_ENDED;
    endtask

    // Advance the parse by one character word and produce its result.
    task automatic parse_char(input t_in_word w, output t_out_word r);
        logic [7:0]  c;
        logic [15:0] pos;
        c = w.text_char;
        if (w.first_char) begin
            phase = P_IDLE;
            mask_acc = '0;
            cur_reg = '0;
            range_lo = '0;
            seen = '0;
        end
        if (phase < P_ENDED) begin
            pos = seen;
            if (pos >= TEXT_MAX - 1) c = CHAR_NUL;
            if (c >= CHAR_LO_A && c <= CHAR_LO_Z) c = c - CASE_DELTA;
            if (seen < TEXT_MAX) seen = seen + 16'd1;
            case (phase)
                P_IDLE: begin
                    if (is_reg_letter(c)) begin
                        cur_reg = (c == CHAR_UP_A) ? 4'd8 : 4'd0;
                        phase = P_LEAD_DIGIT;
                    end else begin
                        phase = P_NAMED;
                    end
                end
                P_LEAD_DIGIT: begin
                    if (is_reg_digit(c)) begin
                        cur_reg = cur_reg | 4'(c - CHAR_ZERO);
                        phase = P_LEAD_SEP;
                    end else begin
                        phase = P_NAMED;
                    end
                end
                P_NEXT_LETTER, P_HI_LETTER: begin
                    if (is_reg_letter(c)) begin
                        if (phase == P_HI_LETTER) range_lo = cur_reg;
                        cur_reg = (c == CHAR_UP_A) ? 4'd8 : 4'd0;
                        phase = (phase == P_NEXT_LETTER) ? P_NEXT_DIGIT : P_HI_DIGIT;
                    end else begin
                        phase = P_BAD;
                    end
                end
                P_NEXT_DIGIT, P_HI_DIGIT: begin
                    if (is_reg_digit(c)) begin
                        cur_reg = cur_reg | 4'(c - CHAR_ZERO);
                        phase = (phase == P_NEXT_DIGIT) ? P_NEXT_SEP : P_HI_END;
                    end else begin
                        phase = P_BAD;
                    end
                end
                P_LEAD_SEP, P_NEXT_SEP: begin
                    if (phase == P_LEAD_SEP && !is_list_end(c)) begin
                        phase = P_NAMED;
                    end else if (c == CHAR_SLASH) begin
                        mask_acc = mask_acc | span_bits(cur_reg, cur_reg);
                        phase = P_NEXT_LETTER;
                    end else if (c == CHAR_DASH) begin
                        phase = P_HI_LETTER;
                    end else begin
                        mask_acc = mask_acc | span_bits(cur_reg, cur_reg);
                        close_list(pos);
                    end
                end
                P_HI_END: begin
                    if (!is_list_end(c) || c == CHAR_DASH) begin
                        phase = P_BAD;
                    end else begin
                        mask_acc = mask_acc | span_bits(range_lo, cur_reg);
                        if (c == CHAR_SLASH) phase = P_NEXT_LETTER;
                        else close_list(pos);
                    end
                end
                default: phase = P_BAD;
            endcase
        end
        r = '0;
        case (phase)
            P_ENDED: begin
                r.parse_status = ST_DONE;
                r.register_mask = mask_acc;
                r.list_length = (seen > 16'd255) ? 8'd255 : seen[7:0];
            end
            P_BAD:   r.parse_status = ST_SYNTAX;
            P_NAMED: r.parse_status = ST_NOT_LIST;
            default: begin
                r.parse_status = ST_BUSY;
                r.register_mask = mask_acc;
            end
        endcase
    endtask

    // Operand text builders
    task automatic put_reg();
        case ($urandom_range(0, 3))
            0: op_chars.push_back(CHAR_UP_A);
            1: op_chars.push_back(CHAR_UP_D);
            2: op_chars.push_back(CHAR_UP_A + CASE_DELTA);
            default: op_chars.push_back(CHAR_UP_D + CASE_DELTA);
        endcase
        op_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
    endtask

    // Build a list, any end byte; a long one runs past the length limit.
    task automatic build_list(input int n_items, input bit long_run);
        int k;
        k = 0;
        op_chars.delete();
        while (long_run ? op_chars.size() < TEXT_MAX + 4 : k < n_items) begin
            if (k > 0) op_chars.push_back(CHAR_SLASH);
            put_reg();
            if ($urandom_range(0, 2) == 0) begin
                op_chars.push_back(CHAR_DASH);
                put_reg();
            end
            k++;
        end
        case ($urandom_range(0, 5))
            0: op_chars.push_back(CHAR_NUL);
            1: op_chars.push_back(CHAR_COMMA);
            2: op_chars.push_back(CHAR_SPACE);
            3: op_chars.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
            4: op_chars.push_back(CHAR_NUL);
            default: op_chars.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic emit_operand();
        t_char_item it;
        bit restart;
        restart = ($urandom_range(0, 9) != 0);
        it.typed = 1'b0;
        it.want = '0;
        foreach (op_chars[i]) begin
            it.w.text_char = op_chars[i];
            it.w.first_char = (i == 0) && restart;
            char_q.push_back(it);
        end
        // trailing characters after the outcome
        repeat ($urandom_range(0, 2)) begin
            it.w.text_char = 8'($urandom_range(0, 255));
            it.w.first_char = 1'b0;
            char_q.push_back(it);
        end
    endtask

    // Handshake: check results, accept characters, drive both sides
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_tick = 0;
    logic [7:0] stall_pat = 8'hFF;

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word pred;
        logic      nv;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    log_fault($sformatf("unexpected result word %h", out_data));
                end else begin
                    want = result_q.pop_front();
                    if (out_data.parse_status !== want.parse_status)
                        log_fault($sformatf("status got %0d want %0d",
                                            out_data.parse_status, want.parse_status));
                    if (out_data.register_mask !== want.register_mask)
                        log_fault($sformatf("mask got %h want %h",
                                            out_data.register_mask, want.register_mask));
                    if (out_data.list_length !== want.list_length)
                        log_fault($sformatf("length got %0d want %0d",
                                            out_data.list_length, want.list_length));
                end
            end

            nv = in_valid;
            if (in_valid && in_ready) begin
                parse_char(in_data, pred);
                result_q.push_back(char_q[0].typed ? char_q[0].want : pred);
                void'(char_q.pop_front());
                nv = 1'b0;
            end
            // hold the word until it is taken
            if (!nv) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (burst_left > 0 && char_q.size() > 0) begin
                    nv = 1'b1;
                    burst_left--;
                    in_data <= char_q[0].w;
                end else if (gap_left > 0) begin
                    gap_left--;
                end
            end
            in_valid <= nv;

            if (stall_tick % 32 == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            out_ready <= stall_pat[stall_tick % 8];
            stall_tick++;
        end
    end

    initial begin
        t_char_item it;
        int sel;
        int keep;
        for (int i = 0; i < DIR_COUNT; i++) begin
            it.w.text_char = DIR_ROWS[i].ch;
            it.w.first_char = DIR_ROWS[i].first;
            it.typed = DIR_ROWS[i].typed;
            it.want.parse_status = DIR_ROWS[i].st;
            it.want.register_mask = DIR_ROWS[i].mask;
            it.want.list_length = DIR_ROWS[i].len;
            char_q.push_back(it);
        end
        build_list(0, 1'b1);
        emit_operand();
        while (char_q.size() < ITEM_GOAL) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                build_list($urandom_range(1, 6), 1'b0);
            end else if (sel < 85) begin
                build_list($urandom_range(1, 4), 1'b0);
                op_chars[$urandom_range(0, op_chars.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (sel < 93) begin
                build_list($urandom_range(1, 4), 1'b0);
                keep = $urandom_range(1, op_chars.size() - 1);
                while (op_chars.size() > keep) void'(op_chars.pop_back());
            end else if (sel < 98) begin
                op_chars.delete();
                repeat ($urandom_range(1, 5)) op_chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_list(0, 1'b1);
            end
            emit_operand();
        end

        while (!i_rst_n) @(posedge i_clk);
        while (char_q.size() > 0 || in_valid) @(posedge i_clk);
        while (result_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (faults == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
design/rlmp_pkg.sv
design/rlmp_char_class.sv
design/register_list_mask_parser.sv
tb/register_list_mask_parser_tb.sv
